FILE: hdl/ps2md_pkg.sv
// Shared types and constants for the PS/2 mouse packet decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ps2md_pkg;

   // Item kinds carried on the request channel's tuser.
   localparam logic CMD_BYTE    = 1'b0;
   localparam logic CMD_REQUEST = 1'b1;

   // Read-and-clear selectors.
   localparam logic [2:0] SEL_LEFT   = 3'd0;
   localparam logic [2:0] SEL_MIDDLE = 3'd1;
   localparam logic [2:0] SEL_RIGHT  = 3'd2;
   localparam logic [2:0] SEL_X      = 3'd3;
   localparam logic [2:0] SEL_Y      = 3'd4;

   // Header byte bit positions.
   localparam int HDR_LEFT   = 0;
   localparam int HDR_RIGHT  = 1;
   localparam int HDR_MIDDLE = 2;
   localparam int HDR_SYNC   = 3;
   localparam int HDR_XSIGN  = 4;
   localparam int HDR_YSIGN  = 5;
   localparam int HDR_XOVF   = 6;
   localparam int HDR_YOVF   = 7;

   // Byte positions within a packet.
   localparam logic [1:0] POS_HEADER = 2'd0;
   localparam logic [1:0] POS_X      = 2'd1;
   localparam logic [1:0] POS_Y      = 2'd2;
   localparam logic [1:0] POS_WHEEL  = 2'd3;

   localparam logic [2:0] BPP_RESET = 3'd3;

   localparam logic signed [15:0] ACC_MAX = 16'sh7FFF;
   localparam logic signed [15:0] ACC_MIN = -16'sh8000;

   typedef struct packed {
      logic       command;
      logic [7:0] data_byte;
      logic [2:0] which;
   } item_type;

   typedef struct packed {
      logic signed [15:0] read_value;
      logic               packet_done;
      logic               byte_dropped;
   } result_type;

endpackage

FILE: hdl/ps2md_core.sv
// Decode state and per-item logic: packet assembly, button latches, accumulators.
// Depends on ps2md_pkg.
`timescale 1ns / 1ps

module ps2md_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [2:0]             csr_value,
   input  logic                   fire,
   input  ps2md_pkg::item_type    item,
   output ps2md_pkg::result_type  result
);
   import ps2md_pkg::*;

   logic [2:0]         bpp_ff, bpp_in;
   logic [1:0]         pos_ff, pos_in;
   logic               xovf_ff, xovf_in, yovf_ff, yovf_in;
   logic               xsign_ff, xsign_in, ysign_ff, ysign_in;
   logic [2:0]         btn_now_ff, btn_now_in;
   logic [2:0]         btn_lat_ff, btn_lat_in;
   logic signed [15:0] xacc_ff, xacc_in, yacc_ff, yacc_in;

   logic               len4;
   logic               last_pos;
   logic [2:0]         hdr_buttons;
   logic signed [8:0]  delta;
   logic signed [15:0] acc_sel;
   logic signed [16:0] acc_sum;
   logic signed [15:0] acc_sat;

   // Shared saturating adder for whichever axis byte is present
   always_comb begin
      len4     = bpp_ff[2];
      last_pos = (pos_ff == POS_WHEEL) || ((pos_ff == POS_Y) && !len4);
      hdr_buttons = {item.data_byte[HDR_RIGHT], item.data_byte[HDR_MIDDLE],
                     item.data_byte[HDR_LEFT]};
      delta   = (pos_ff == POS_X) ? {xsign_ff, item.data_byte} : {ysign_ff, item.data_byte};
      acc_sel = (pos_ff == POS_X) ? xacc_ff : yacc_ff;
      acc_sum = 17'(acc_sel) + 17'(delta);
      if (acc_sum > 17'(ACC_MAX)) begin
         acc_sat = ACC_MAX;
      end else if (acc_sum < 17'(ACC_MIN)) begin
         acc_sat = ACC_MIN;
      end else begin
         acc_sat = acc_sum[15:0];
      end
   end

   // Next state and result for the item in the input register
   always_comb begin
      bpp_in     = csr_write ? csr_value : bpp_ff;
      pos_in     = pos_ff;
      xovf_in    = xovf_ff;
      yovf_in    = yovf_ff;
      xsign_in   = xsign_ff;
      ysign_in   = ysign_ff;
      btn_now_in = btn_now_ff;
      btn_lat_in = btn_lat_ff;
      xacc_in    = xacc_ff;
      yacc_in    = yacc_ff;
      result     = '0;

      if (item.command == CMD_REQUEST) begin
         case (item.which)
            SEL_LEFT, SEL_MIDDLE, SEL_RIGHT: begin
               result.read_value = {15'd0, btn_lat_ff[item.which[1:0]]};
               btn_lat_in[item.which[1:0]] = btn_now_ff[item.which[1:0]];
            end
            SEL_X: begin
               result.read_value = xacc_ff;
               xacc_in = '0;
            end
            SEL_Y: begin
               result.read_value = yacc_ff;
               yacc_in = '0;
            end
            default: ;
         endcase
      end else if ((pos_ff == POS_HEADER) && !item.data_byte[HDR_SYNC]) begin
         // Out of sync: drop and wait for a header
         result.byte_dropped = 1'b1;
      end else begin
         case (pos_ff)
            POS_HEADER: begin
               btn_now_in = hdr_buttons;
               btn_lat_in = btn_lat_ff | hdr_buttons;
               xsign_in   = item.data_byte[HDR_XSIGN];
               ysign_in   = item.data_byte[HDR_YSIGN];
               xovf_in    = item.data_byte[HDR_XOVF];
               yovf_in    = item.data_byte[HDR_YOVF];
            end
            POS_X: begin
               if (!xovf_ff) xacc_in = acc_sat;
            end
            POS_Y: begin
               if (!yovf_ff) yacc_in = acc_sat;
            end
            default: ;  // wheel byte is ignored
         endcase
         if (last_pos) begin
            pos_in = POS_HEADER;
            result.packet_done = 1'b1;
         end else begin
            pos_in = pos_ff + 2'd1;
         end
      end
   end

   // Decode state advances only on a transfer into the result stage; bpp_ff on each config write
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff     <= BPP_RESET;
         pos_ff     <= POS_HEADER;
         xovf_ff    <= 1'b0;
         yovf_ff    <= 1'b0;
         xsign_ff   <= 1'b0;
         ysign_ff   <= 1'b0;
         btn_now_ff <= '0;
         btn_lat_ff <= '0;
         xacc_ff    <= '0;
         yacc_ff    <= '0;
      end else begin
         bpp_ff <= bpp_in;
         if (fire) begin
            pos_ff     <= pos_in;
            xovf_ff    <= xovf_in;
            yovf_ff    <= yovf_in;
            xsign_ff   <= xsign_in;
            ysign_ff   <= ysign_in;
            btn_now_ff <= btn_now_in;
            btn_lat_ff <= btn_lat_in;
            xacc_ff    <= xacc_in;
            yacc_ff    <= yacc_in;
         end
      end
   end

   a_drop_keeps_header: assert property (@(posedge clock) disable iff (reset)
      fire && result.byte_dropped |=> pos_ff == POS_HEADER)
      else $error("dropped header byte moved the packet position");

   a_done_restarts: assert property (@(posedge clock) disable iff (reset)
      fire && result.packet_done |=> pos_ff == POS_HEADER)
      else $error("completed packet did not return to header position");

   a_x_read_clears: assert property (@(posedge clock) disable iff (reset)
      fire && item.command == CMD_REQUEST && item.which == SEL_X |=> xacc_ff == '0)
      else $error("X accumulator not cleared after read");

   a_drop_no_done: assert property (@(posedge clock) disable iff (reset)
      fire |-> !(result.byte_dropped && result.packet_done))
      else $error("byte both dropped and completing a packet");

endmodule

FILE: hdl/ps2md_out_reg.sv
// Result register stage on the response channel.
// Depends on ps2md_pkg.
`timescale 1ns / 1ps

module ps2md_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  ps2md_pkg::result_type  load_data,
   output logic                   can_load,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output ps2md_pkg::result_type  rsp_data
);
   import ps2md_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   // Free when empty or when the held result transfers this cycle
   assign can_load = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) data_ff <= load_data;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_data   = data_ff;

endmodule

FILE: hdl/ps2md_in_reg.sv
// Input register stage on the request channel.
// Depends on ps2md_pkg.
`timescale 1ns / 1ps

module ps2md_in_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  ps2md_pkg::item_type  req_item,
   input  logic                 take,
   output logic                 held_valid,
   output ps2md_pkg::item_type  held_item
);
   import ps2md_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;

   // Accept when empty or when the held item moves on this cycle
   assign req_tready = !valid_ff || take;
   assign valid_in   = (req_tvalid && req_tready) || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tvalid && req_tready) item_ff <= req_item;
   end

   assign held_valid = valid_ff;
   assign held_item  = item_ff;

endmodule

FILE: hdl/ps2_mouse_packet_decoder_top.sv
// PS/2 mouse packet decoder, top level.
// Depends on ps2md_pkg, ps2md_in_reg, ps2md_core, ps2md_out_reg.
//
// Request channel (req_*): each transfer is a mouse byte (tuser = 0) or a
// read-and-clear request (tuser = 1). Bytes build 3- or 4-byte packets; the
// header sets buttons, sticky press latches, sign and overflow bits, and the
// X and Y bytes add into saturating 16-bit accumulators unless overflowed.
// Requests return and reset a latch (to its held button) or an accumulator.
// Response channel (rsp_*): exactly one result per request transfer, in order.
// tdata is the read value, tlast marks a byte that completed a packet and
// tuser flags a header byte dropped for a clear sync bit.
// Config channel (csr_*): writes the packet length; always ready. The user must
// write it only while the block is idle; the block itself does not enforce this.
// A request passes from its transfer through the input register, then the
// result register, to response valid. Throughput: one item per cycle while
// rsp_tready stays high, set by the single decode stage between the registers.
// Reset clears all decode state, latches and accumulators; the length
// returns to 3. When the receiver stalls, the result register holds, the
// input register still takes one more item, then req_tready drops.
`timescale 1ns / 1ps

module ps2_mouse_packet_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [10:8] which, [15:11] zero
   input  logic        req_tuser,   // [0] command
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] read_value
   output logic        rsp_tlast,   // packet_done
   output logic        rsp_tuser,   // [0] byte_dropped
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_data     // bytes_per_packet
);
   import ps2md_pkg::*;

   item_type   req_item, held_item;
   logic       held_valid, can_load, fire;
   result_type result, rsp_data;

   assign req_item.command   = req_tuser;
   assign req_item.data_byte = req_tdata[7:0];
   assign req_item.which     = req_tdata[10:8];

   assign csr_ready = 1'b1;
   assign fire      = held_valid && can_load;

   ps2md_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_item   (req_item),
      .take       (fire),
      .held_valid (held_valid),
      .held_item  (held_item)
   );

   ps2md_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_value (csr_data),
      .fire      (fire),
      .item      (held_item),
      .result    (result)
   );

   ps2md_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (fire),
      .load_data  (result),
      .can_load   (can_load),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = rsp_data.read_value;
   assign rsp_tlast = rsp_data.packet_done;
   assign rsp_tuser = rsp_data.byte_dropped;

endmodule

FILE: verif/ps2md_checker.sv
// Scoreboard for the PS/2 mouse packet decoder: watches the request, response
// and config channels, predicts each response and compares it field by field.
// Depends on ps2md_pkg for the item and result types and the bit constants.
`timescale 1ns / 1ps

module ps2md_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] data_byte, [10:8] which, [15:11] zero
   input  logic        req_tuser,   // [0] command
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,   // [15:0] read_value
   input  logic        rsp_tlast,   // packet_done
   input  logic        rsp_tuser,   // [0] byte_dropped
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [2:0]  csr_data,    // bytes_per_packet
   output int          error_count,
   output int          pending_count
);
   import ps2md_pkg::*;

   // Shadow copy of the decoder state
   logic [2:0]         packet_len_reg;
   logic [1:0]         byte_pos;
   logic               x_ovf;
   logic               y_ovf;
   logic               x_neg;
   logic               y_neg;
   logic [2:0]         buttons_held;
   logic [2:0]         buttons_pressed;
   logic signed [15:0] x_total;
   logic signed [15:0] y_total;
   int                 mismatches;

   // Responses still owed by the block, oldest first
   result_type decoded_results_q[$];

   initial begin
      error_count   = 0;
      pending_count = 0;
      mismatches    = 0;
   end

   // Add a 9-bit signed delta to an accumulator, clamped to 16 bits
   function automatic logic signed [15:0] add_saturated(logic signed [15:0] acc,
                                                        logic [7:0] low, logic neg);
      int sum;
      sum = int'(acc) + int'(low) - (neg ? 256 : 0);
      if (sum > int'(ACC_MAX))
         sum = int'(ACC_MAX);
      if (sum < int'(ACC_MIN))
         sum = int'(ACC_MIN);
      return 16'(sum);
   endfunction

   // Apply one accepted item to the shadow state and return its response
   task automatic decode_mouse_item(input item_type it, output result_type res);
      int         len;
      logic [2:0] mask;
      res = '0;
      if (it.command == CMD_REQUEST) begin
         case (it.which)
            SEL_LEFT, SEL_MIDDLE, SEL_RIGHT: begin
               mask = 3'b001 << it.which;
               res.read_value = ((buttons_pressed & mask) != 3'b000) ? 16'sd1 : 16'sd0;
               buttons_pressed = (buttons_pressed & ~mask) | (buttons_held & mask);
            end
            SEL_X: begin
               res.read_value = x_total;
               x_total = '0;
            end
            SEL_Y: begin
               res.read_value = y_total;
               y_total = '0;
            end
            default: ;
         endcase
      end else begin
         len = (packet_len_reg >= 3'd4) ? 4 : 3;
         if (byte_pos == POS_HEADER && !it.data_byte[HDR_SYNC]) begin
            // out of sync: drop the byte, stay at the header position
            res.byte_dropped = 1'b1;
         end else begin
            case (byte_pos)
               POS_HEADER: begin
                  buttons_held = {it.data_byte[HDR_RIGHT], it.data_byte[HDR_MIDDLE],
                                  it.data_byte[HDR_LEFT]};
                  buttons_pressed = buttons_pressed | buttons_held;
                  x_neg = it.data_byte[HDR_XSIGN];
                  y_neg = it.data_byte[HDR_YSIGN];
                  x_ovf = it.data_byte[HDR_XOVF];
                  y_ovf = it.data_byte[HDR_YOVF];
               end
               POS_X: begin
                  if (!x_ovf)
                     x_total = add_saturated(x_total, it.data_byte, x_neg);
               end
               POS_Y: begin
                  if (!y_ovf)
                     y_total = add_saturated(y_total, it.data_byte, y_neg);
               end
               default: ;   // wheel byte is consumed and ignored
            endcase
            // a shortened length completes the packet at once
            if (int'(byte_pos) + 1 >= len) begin
               byte_pos = POS_HEADER;
               res.packet_done = 1'b1;
            end else begin
               byte_pos = byte_pos + 2'd1;
            end
         end
      end
   endtask

   // Track config writes, compare responses, predict requests
   always @(posedge clock) begin : monitor
      result_type got;
      result_type want;
      item_type   it;
      if (reset) begin
         packet_len_reg  = BPP_RESET;
         byte_pos        = POS_HEADER;
         x_ovf           = 1'b0;
         y_ovf           = 1'b0;
         x_neg           = 1'b0;
         y_neg           = 1'b0;
         buttons_held    = '0;
         buttons_pressed = '0;
         x_total         = '0;
         y_total         = '0;
         decoded_results_q.delete();
      end else begin
         if (csr_valid && csr_ready)
            packet_len_reg = csr_data;
         if (rsp_tvalid && rsp_tready) begin
            got.read_value   = rsp_tdata;
            got.packet_done  = rsp_tlast;
            got.byte_dropped = rsp_tuser;
            if (decoded_results_q.size() == 0) begin
               $display("%0t: ERROR unexpected response, actual value %h done %b dropped %b",
                        $time, got.read_value, got.packet_done, got.byte_dropped);
               mismatches++;
            end else begin
               want = decoded_results_q.pop_front();
               if (got.read_value !== want.read_value) begin
                  $display("%0t: ERROR read_value expected %h actual %h",
                           $time, want.read_value, got.read_value);
                  mismatches++;
               end
               if (got.packet_done !== want.packet_done) begin
                  $display("%0t: ERROR packet_done expected %b actual %b",
                           $time, want.packet_done, got.packet_done);
                  mismatches++;
               end
               if (got.byte_dropped !== want.byte_dropped) begin
                  $display("%0t: ERROR byte_dropped expected %b actual %b",
                           $time, want.byte_dropped, got.byte_dropped);
                  mismatches++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            it.command   = req_tuser;
            it.data_byte = req_tdata[7:0];
            it.which     = req_tdata[10:8];
            decode_mouse_item(it, want);
            decoded_results_q.push_back(want);
         end
      end
      pending_count <= decoded_results_q.size();
      error_count   <= mismatches;
   end

endmodule

FILE: verif/tb_ps2_mouse_packet_decoder_top.sv
// Testbench top for the PS/2 mouse packet decoder: clock, reset, stimulus,
// random back-pressure and the verdict. Depends on ps2md_pkg, ps2md_checker
// and the ps2_mouse_packet_decoder_top RTL.
`timescale 1ns / 1ps

module tb_ps2_mouse_packet_decoder_top;
   import ps2md_pkg::*;

   localparam int STALL_LIMIT = 1000;
   localparam int SAT_PACKETS = 140;
   localparam int PHASE_ITEMS = 22;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        req_tuser  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_data   = '0;

   bit          quiet = 1'b0;
   int          error_count;
   int          pending_count;
   int          stall_cycles = 0;

   ps2_mouse_packet_decoder_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   ps2md_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Stall the response side at random, except during quiet stretches
   always @(posedge clock) begin
      rsp_tready <= quiet || ($urandom_range(0, 99) >= 19);
   end

   // End the run if nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Offer one item, with an occasional gap before it, and hold until transfer
   task automatic send_item(input logic cmd, input logic [7:0] data, input logic [2:0] sel);
      if (!quiet && $urandom_range(0, 99) < 12) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {5'b00000, sel, data};
      req_tuser  <= cmd;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_packet(input int len, input logic [7:0] hdr,
                              input logic [7:0] x_byte, input logic [7:0] y_byte);
      send_item(CMD_BYTE, hdr, 3'($urandom));
      send_item(CMD_BYTE, x_byte, 3'($urandom));
      send_item(CMD_BYTE, y_byte, 3'($urandom));
      if (len == 4)
         send_item(CMD_BYTE, 8'($urandom), 3'($urandom));
   endtask

   task automatic send_request(input logic [2:0] sel);
      send_item(CMD_REQUEST, 8'($urandom), sel);
   endtask

   // Hold off until every owed response has come, then let the pipe settle
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_packet_len(input logic [2:0] len_value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= len_value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Long run of same-direction motion to drive both accumulators into clamping
   task automatic saturate_axes(input logic x_down);
      logic [7:0] hdr;
      logic [7:0] x_byte;
      logic [7:0] y_byte;
      for (int p = 0; p < SAT_PACKETS; p++) begin
         hdr = 8'($urandom);
         hdr[HDR_SYNC]  = 1'b1;
         hdr[HDR_XOVF]  = 1'b0;
         hdr[HDR_YOVF]  = 1'b0;
         hdr[HDR_XSIGN] = x_down;
         hdr[HDR_YSIGN] = !x_down;
         x_byte = x_down ? 8'($urandom_range(0, 15)) : 8'($urandom_range(240, 255));
         y_byte = x_down ? 8'($urandom_range(240, 255)) : 8'($urandom_range(0, 15));
         send_packet(3, hdr, x_byte, y_byte);
      end
      send_request(SEL_X);
      send_request(SEL_Y);
      send_request(SEL_X);
   endtask

   initial begin : stimulus
      logic [2:0] lengths[10];
      logic [7:0] hdr;
      int         len;
      int         count;
      int         pick;

      lengths = '{3'd4, 3'd0, 3'd7, 3'd3, 3'd5, 3'd1, 3'd6, 3'd2, 3'd4, 3'd3};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_packet_len(3'd3);

      // Directed: every selector from reset, sync drops, extremes of the deltas
      for (int s = 0; s < 8; s++)
         send_request(3'(s));
      send_item(CMD_BYTE, 8'h00, 3'd7);
      send_item(CMD_BYTE, 8'hF7, 3'd0);
      send_packet(3, 8'h0F, 8'hFF, 8'h00);
      send_request(SEL_LEFT);
      send_request(SEL_LEFT);
      send_packet(3, 8'h38, 8'h00, 8'h01);
      send_request(SEL_MIDDLE);
      send_packet(3, 8'hC8, 8'h80, 8'h7F);
      send_request(SEL_X);
      send_request(SEL_Y);

      // Saturation runs, the first with no idling on either side
      quiet = 1'b1;
      saturate_axes(1'b0);
      quiet = 1'b0;
      saturate_axes(1'b1);
      for (int s = 0; s < 3; s++)
         send_request(3'(s));

      // Random phases, one per packet length setting
      foreach (lengths[i]) begin
         write_packet_len(lengths[i]);
         len = (lengths[i] >= 3'd4) ? 4 : 3;
         count = 0;
         while (count < PHASE_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) begin
               hdr = 8'($urandom);
               hdr[HDR_SYNC] = 1'b1;
               if ($urandom_range(0, 3) != 0)
                  hdr[HDR_YOVF:HDR_XOVF] = 2'b00;
               send_packet(len, hdr, 8'($urandom), 8'($urandom));
               count += len;
            end else if (pick < 85) begin
               send_request(3'($urandom));
               count++;
            end else begin
               send_item(CMD_BYTE, 8'($urandom), 3'($urandom));
               count++;
            end
         end
         // leave a packet half done so the next length meets it mid-packet
         if ($urandom_range(0, 1) == 1) begin
            hdr = 8'($urandom);
            hdr[HDR_SYNC] = 1'b1;
            send_item(CMD_BYTE, hdr, 3'($urandom));
            send_item(CMD_BYTE, 8'($urandom), 3'($urandom));
            if (len == 4)
               send_item(CMD_BYTE, 8'($urandom), 3'($urandom));
         end
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

FILE: ps2_mouse_packet_decoder_top.f
hdl/ps2md_pkg.sv
hdl/ps2md_core.sv
hdl/ps2md_out_reg.sv
hdl/ps2md_in_reg.sv
hdl/ps2_mouse_packet_decoder_top.sv
verif/ps2md_checker.sv
verif/tb_ps2_mouse_packet_decoder_top.sv
